FILE: rtl/core/aels_pkg.sv
// Shared types and constants of the auto-exposure level stepper.
`timescale 1ns / 1ps

package aels_pkg;

   localparam int LUMA_WIDTH      = 8;
   localparam int LEVEL_WIDTH     = 8;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 8;
   localparam int STEP_WIDTH      = 4;

   // Smoothing and control loop constants.
   localparam logic [LUMA_WIDTH-1:0]  JUMP_LIMIT = 8'd20;
   localparam logic [LUMA_WIDTH-1:0]  HOLD_BAND  = 8'd6;
   localparam logic [LUMA_WIDTH-1:0]  STEP_BAND  = 8'd4;
   localparam logic [LUMA_WIDTH-1:0]  ERR_HUGE   = 8'd80;
   localparam logic [LUMA_WIDTH-1:0]  ERR_LARGE  = 8'd40;
   localparam logic [LUMA_WIDTH-1:0]  ERR_MEDIUM = 8'd20;
   localparam logic [LUMA_WIDTH-1:0]  ERR_SMALL  = 8'd10;
   localparam logic [STEP_WIDTH-1:0]  STEP_HUGE   = 4'd8;
   localparam logic [STEP_WIDTH-1:0]  STEP_LARGE  = 4'd6;
   localparam logic [STEP_WIDTH-1:0]  STEP_MEDIUM = 4'd4;
   localparam logic [STEP_WIDTH-1:0]  STEP_SMALL  = 4'd2;
   localparam logic [STEP_WIDTH-1:0]  STEP_TINY   = 4'd1;

   // Reset values.
   localparam logic [LUMA_WIDTH-1:0]  LUMA_RESET      = 8'd60;
   localparam logic [LEVEL_WIDTH-1:0] LEVEL_RESET     = 8'd80;
   localparam logic [LUMA_WIDTH-1:0]  TARGET_RESET    = 8'd60;
   localparam logic [LEVEL_WIDTH-1:0] MAX_LEVEL_RESET = 8'd160;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_TARGET_LUMA = 8'd0,
      CSR_MAX_LEVEL   = 8'd1
   } aels_csr_type;

   typedef struct packed {
      logic [LUMA_WIDTH-1:0]  target_luma;
      logic [LEVEL_WIDTH-1:0] max_level;
   } aels_cfg_type;

   typedef struct packed {
      logic [LEVEL_WIDTH-1:0] level;
      logic                   stable;
   } aels_loop_type;

endpackage

FILE: rtl/core/aels_smooth.sv
// Jump-aware smoothing of the frame mean luma against the kept luma.
`timescale 1ns / 1ps

module aels_smooth (
   input  logic [aels_pkg::LUMA_WIDTH-1:0] frame_luma,
   input  logic [aels_pkg::LUMA_WIDTH-1:0] kept_luma,
   output logic [aels_pkg::LUMA_WIDTH-1:0] smoothed_luma
);
   import aels_pkg::*;

   logic [LUMA_WIDTH-1:0] luma_gap;
   logic [LUMA_WIDTH+1:0] blend_sum;

   always_comb begin
      luma_gap = (frame_luma > kept_luma) ? (frame_luma - kept_luma)
                                          : (kept_luma - frame_luma);
      // 3*new + old + 2 fits in ten bits; the quarter never exceeds 255.
      blend_sum = ({2'b00, frame_luma} << 1) + {2'b00, frame_luma} + {2'b00, kept_luma}
                + 10'd2;
      if (luma_gap > JUMP_LIMIT) begin
         smoothed_luma = frame_luma;
      end else begin
         smoothed_luma = blend_sum[LUMA_WIDTH+1:2];
      end
   end

endmodule

FILE: rtl/core/aels_ctrl.sv
// Exposure level stepping, deadband hold and clamping.
`timescale 1ns / 1ps

module aels_ctrl (
   input  logic [aels_pkg::LUMA_WIDTH-1:0] smoothed_luma,
   input  aels_pkg::aels_cfg_type          cfg,
   input  aels_pkg::aels_loop_type         loop_cur,
   output aels_pkg::aels_loop_type         loop_next
);
   import aels_pkg::*;

   logic                    below;
   logic [LUMA_WIDTH-1:0]   mag;
   logic [STEP_WIDTH-1:0]   step;
   logic [LEVEL_WIDTH+1:0]  lvl_wide;

   always_comb begin
      below = smoothed_luma < cfg.target_luma;
      mag   = below ? (cfg.target_luma - smoothed_luma)
                    : (smoothed_luma - cfg.target_luma);

      priority if (mag > ERR_HUGE)   step = STEP_HUGE;
      else if     (mag > ERR_LARGE)  step = STEP_LARGE;
      else if     (mag > ERR_MEDIUM) step = STEP_MEDIUM;
      else if     (mag > ERR_SMALL)  step = STEP_SMALL;
      else                           step = STEP_TINY;

      // Ten-bit intermediate whose top bit flags a borrow, so stepping never wraps.
      lvl_wide  = {2'b00, loop_cur.level};
      loop_next = loop_cur;

      if (!(loop_cur.stable && (mag <= HOLD_BAND))) begin
         if (mag >= STEP_BAND) begin
            if (below) begin
               lvl_wide = {2'b00, loop_cur.level} + {6'b000000, step};
            end else begin
               lvl_wide = {2'b00, loop_cur.level} - {6'b000000, step};
            end
            loop_next.stable = 1'b0;
         end else begin
            loop_next.stable = 1'b1;
         end

         if (lvl_wide[LEVEL_WIDTH+1]) begin
            loop_next.level = '0;
         end else if (lvl_wide[LEVEL_WIDTH:0] > {1'b0, cfg.max_level}) begin
            loop_next.level = cfg.max_level;
         end else begin
            loop_next.level = lvl_wide[LEVEL_WIDTH-1:0];
         end
      end
   end

endmodule

FILE: rtl/core/auto_exposure_level_stepper_unit.sv
// An accepted request transaction passes through the input register, then the result register.
// Throughput: one transaction per cycle unless the response side stalls; the loop state closes
// through the smoothing and stepping logic between the input register and the result register.
// Reset (synchronous, active high) empties both stages, loads kept luma 60,
// exposure level 80, stable flag clear, target luma 60 and maximum level 160.
`timescale 1ns / 1ps

module auto_exposure_level_stepper_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel: one frame mean luma per transaction.
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [aels_pkg::LUMA_WIDTH-1:0]      req_mean_luma,
   // Response channel.
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [aels_pkg::LEVEL_WIDTH-1:0]     rsp_level_index,
   output logic [aels_pkg::LUMA_WIDTH-1:0]      rsp_smoothed_luma,
   output logic                                 rsp_is_stable,
   // Register write channel.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [aels_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [aels_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import aels_pkg::*;

   // Input stage.
   logic                  in_valid_ff, in_valid_in;
   logic [LUMA_WIDTH-1:0] in_luma_ff;

   // Loop state, updated when a transaction moves into the result register.
   logic [LUMA_WIDTH-1:0] kept_luma_ff, kept_luma_in;
   aels_loop_type         loop_ff, loop_in;

   // Configuration registers.
   aels_cfg_type          cfg_ff, cfg_in;

   // Result stage.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_WIDTH-1:0] rsp_level_ff;
   logic [LUMA_WIDTH-1:0]  rsp_luma_ff;
   logic                   rsp_stable_ff;

   logic                  advance;
   logic                  req_fire;
   logic [LUMA_WIDTH-1:0] smoothed;
   aels_loop_type         loop_next;

   // The result register is free when empty or being drained this cycle, and the
   // input register may take a new transaction when it is empty or its content moves on.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   aels_smooth u_smooth (
      .frame_luma    (in_luma_ff),
      .kept_luma     (kept_luma_ff),
      .smoothed_luma (smoothed)
   );

   aels_ctrl u_ctrl (
      .smoothed_luma (smoothed),
      .cfg           (cfg_ff),
      .loop_cur      (loop_ff),
      .loop_next     (loop_next)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      kept_luma_in = kept_luma_ff;
      loop_in      = loop_ff;
      cfg_in       = cfg_ff;

      if (advance) begin
         in_valid_in  = req_fire;
         rsp_valid_in = in_valid_ff;
         // The state moves only when a transaction actually completes its pass.
         if (in_valid_ff) begin
            kept_luma_in = smoothed;
            loop_in      = loop_next;
         end
      end else if (req_fire) begin
         in_valid_in = 1'b1;
      end

      // Writes to an index outside the register list are dropped.
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TARGET_LUMA: cfg_in.target_luma = csr_data[LUMA_WIDTH-1:0];
            CSR_MAX_LEVEL:   cfg_in.max_level   = csr_data[LEVEL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         kept_luma_ff       <= LUMA_RESET;
         loop_ff.level      <= LEVEL_RESET;
         loop_ff.stable     <= 1'b0;
         cfg_ff.target_luma <= TARGET_RESET;
         cfg_ff.max_level   <= MAX_LEVEL_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         kept_luma_ff <= kept_luma_in;
         loop_ff      <= loop_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_luma_ff <= req_mean_luma;
      end
      if (advance && in_valid_ff) begin
         rsp_level_ff  <= loop_next.level;
         rsp_luma_ff   <= smoothed;
         rsp_stable_ff <= loop_next.stable;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_level_index   = rsp_level_ff;
   assign rsp_smoothed_luma = rsp_luma_ff;
   assign rsp_is_stable     = rsp_stable_ff;

endmodule

FILE: rtl/core/aels_checker.sv
// Port-level checks of the auto-exposure level stepper and their binding.
`timescale 1ns / 1ps

module aels_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic [aels_pkg::LUMA_WIDTH-1:0]      req_mean_luma,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [aels_pkg::LEVEL_WIDTH-1:0]     rsp_level_index,
   input logic [aels_pkg::LUMA_WIDTH-1:0]      rsp_smoothed_luma,
   input logic                                 rsp_is_stable,
   input logic                                 csr_valid,
   input logic                                 csr_ready,
   input logic [aels_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input logic [aels_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   // A stalled response holds its valid and payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_level_index)
         && $stable(rsp_smoothed_luma) && $stable(rsp_is_stable))
      else $error("response changed while stalled");

   // A waiting request keeps its valid and its luma until it is taken.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_mean_luma))
      else $error("request changed while waiting");

   // Requests are only held off while a full result register is stalled.
   a_req_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without downstream back-pressure");

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // The register port never pushes back and always carries a defined write.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready && !$isunknown({csr_index, csr_data}))
      else $error("register write refused or undefined");

endmodule

bind auto_exposure_level_stepper_unit aels_checker u_aels_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_mean_luma     (req_mean_luma),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_level_index   (rsp_level_index),
   .rsp_smoothed_luma (rsp_smoothed_luma),
   .rsp_is_stable     (rsp_is_stable),
   .csr_valid         (csr_valid),
   .csr_ready         (csr_ready),
   .csr_index         (csr_index),
   .csr_data          (csr_data)
);

FILE: test/auto_exposure_level_stepper_unit_tb.sv
// Self-checking testbench for the auto-exposure level stepper unit.
`timescale 1ns / 1ps

module auto_exposure_level_stepper_unit_tb;

   import aels_pkg::*;

   // One expected response: the level, the smoothed luma and the stable flag.
   typedef struct packed {
      logic [LEVEL_WIDTH-1:0] level;
      logic [LUMA_WIDTH-1:0]  luma;
      logic                   stable;
   } exposure_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [LUMA_WIDTH-1:0]      req_mean_luma = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [LEVEL_WIDTH-1:0]     rsp_level_index;
   logic [LUMA_WIDTH-1:0]      rsp_smoothed_luma;
   logic                       rsp_is_stable;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;

   auto_exposure_level_stepper_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mean_luma     (req_mean_luma),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_level_index   (rsp_level_index),
      .rsp_smoothed_luma (rsp_smoothed_luma),
      .rsp_is_stable     (rsp_is_stable),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #4 clock = ~clock;

   // Frames still to be offered, and responses predicted but not yet seen.
   logic [LUMA_WIDTH-1:0] frame_queue[$];
   exposure_result_type   awaited_exposure[$];

   // The testbench's own copy of the loop state and the two registers.
   logic [LUMA_WIDTH-1:0]  loop_kept_luma = LUMA_RESET;
   logic [LEVEL_WIDTH-1:0] loop_level     = LEVEL_RESET;
   logic                   loop_stable    = 1'b0;
   logic [LUMA_WIDTH-1:0]  cfg_target     = TARGET_RESET;
   logic [LEVEL_WIDTH-1:0] cfg_max_level  = MAX_LEVEL_RESET;

   int  frames_queued   = 0;
   int  frames_accepted = 0;
   int  responses_seen  = 0;
   int  writes_seen     = 0;
   int  holds_seen      = 0;
   int  failures        = 0;
   int  sender_gap      = 0;
   int  receiver_hold   = 0;
   logic frame_taken    = 1'b0;
   // Set for the closing stretch of the run, where neither side idles.
   logic calm           = 1'b0;

   // Step size chosen by the magnitude of the luma error.
   function automatic int step_for_error(input int magnitude);
      if (magnitude > int'(ERR_HUGE))   return int'(STEP_HUGE);
      if (magnitude > int'(ERR_LARGE))  return int'(STEP_LARGE);
      if (magnitude > int'(ERR_MEDIUM)) return int'(STEP_MEDIUM);
      if (magnitude > int'(ERR_SMALL))  return int'(STEP_SMALL);
      return int'(STEP_TINY);
   endfunction

   // Advances the predicted loop by one frame and returns the response it should give.
   function automatic exposure_result_type advance_loop(
      input logic [LUMA_WIDTH-1:0] frame_luma);
      int distance;
      int smoothed;
      int error;
      int magnitude;
      int level;
      exposure_result_type result;
      distance = int'(frame_luma) - int'(loop_kept_luma);
      if (distance < 0) distance = -distance;
      // A large jump is taken as it is; small changes are blended with the kept value.
      if (distance > int'(JUMP_LIMIT)) begin
         smoothed = int'(frame_luma);
      end else begin
         smoothed = (3 * int'(frame_luma) + int'(loop_kept_luma) + 2) >> 2;
         if (smoothed > 255) smoothed = 255;
      end
      loop_kept_luma = smoothed[LUMA_WIDTH-1:0];
      error = smoothed - int'(cfg_target);
      magnitude = (error < 0) ? -error : error;
      if (magnitude <= int'(HOLD_BAND) && loop_stable) begin
         // Held exactly as it was, without clamping to the present maximum.
         holds_seen++;
      end else begin
         level = int'(loop_level);
         if (magnitude >= int'(STEP_BAND)) begin
            level = (error > 0) ? level - step_for_error(magnitude)
                                : level + step_for_error(magnitude);
            loop_stable = 1'b0;
         end else begin
            loop_stable = 1'b1;
         end
         if (level < 0) level = 0;
         else if (level > int'(cfg_max_level)) level = int'(cfg_max_level);
         loop_level = level[LEVEL_WIDTH-1:0];
      end
      result.level  = loop_level;
      result.luma   = loop_kept_luma;
      result.stable = loop_stable;
      return result;
   endfunction

   // Monitor: everything is sampled at the rising edge, before the block updates.
   always @(posedge clock) begin
      exposure_result_type want;
      if (reset) begin
         frame_taken <= 1'b0;
      end else begin
         frame_taken <= req_valid && req_ready;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TARGET_LUMA: cfg_target    = csr_data;
               CSR_MAX_LEVEL:   cfg_max_level = csr_data;
               default: ;
            endcase
            writes_seen++;
         end
         if (req_valid && req_ready) begin
            awaited_exposure.push_back(advance_loop(req_mean_luma));
            frames_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            responses_seen++;
            if (awaited_exposure.size() == 0) begin
               $error("response transaction with nothing expected: level %0d luma %0d stable %0b",
                      rsp_level_index, rsp_smoothed_luma, rsp_is_stable);
               failures++;
            end else begin
               want = awaited_exposure.pop_front();
               if (rsp_level_index !== want.level) begin
                  $error("level_index: expected %0d, got %0d", want.level, rsp_level_index);
                  failures++;
               end
               if (rsp_smoothed_luma !== want.luma) begin
                  $error("smoothed_luma: expected %0d, got %0d", want.luma, rsp_smoothed_luma);
                  failures++;
               end
               if (rsp_is_stable !== want.stable) begin
                  $error("is_stable: expected %0b, got %0b", want.stable, rsp_is_stable);
                  failures++;
               end
            end
         end
      end
   end

   // Driver: offers queued frames at the falling edge. A frame stays on the port until it
   // has been accepted, and after an accepted transaction the sender sometimes goes quiet
   // for a burst of cycles.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || frame_taken) begin
         if (frame_taken && !calm && $urandom_range(0, 5) == 0)
            sender_gap = $urandom_range(1, 14);
         if (sender_gap > 0) begin
            sender_gap--;
            req_valid <= 1'b0;
         end else if (frame_queue.size() > 0) begin
            req_valid     <= 1'b1;
            req_mean_luma <= frame_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: alternates runs of ready with stalls.
   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_ready <= 1'b1;
      end else if (receiver_hold > 0) begin
         receiver_hold--;
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_ready     <= 1'b0;
         receiver_hold = $urandom_range(0, 13);
      end else begin
         rsp_ready     <= 1'b1;
         receiver_hold = $urandom_range(0, 30);
      end
   end

   task automatic queue_frame(input int luma);
      if (luma < 0) luma = 0;
      if (luma > 255) luma = 255;
      frame_queue.push_back(luma[LUMA_WIDTH-1:0]);
      frames_queued++;
   endtask

   // Holds the test sequence back until every queued frame has been accepted and answered.
   task automatic wait_for_drain();
      while (frames_accepted != frames_queued || awaited_exposure.size() != 0)
         @(negedge clock);
   endtask

   // One register write transaction; only called while the block is idle.
   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   // Random frames for one phase: mostly values around the target so that the loop settles
   // and the hold path is reached, some slow drift, and some full-range noise and jumps.
   task automatic queue_random_phase(input int count, input int target);
      int luma;
      int pick;
      luma = target;
      repeat (count) begin
         pick = $urandom_range(0, 9);
         if (pick < 5)
            luma = target + $urandom_range(0, 24) - 12;
         else if (pick < 8)
            luma = luma + $urandom_range(0, 10) - 5;
         else
            luma = $urandom_range(0, 255);
         if (luma < 0) luma = 0;
         if (luma > 255) luma = 255;
         queue_frame(luma);
      end
   endtask

   initial begin
      int target;
      int max_level;
      int phase;
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed part, under the reset register values. The loop settles at the target,
      // then is knocked about by both luma extremes, by a change of exactly the jump limit
      // (blended) and by changes just over it (taken as they are).
      queue_frame(60);  queue_frame(61);  queue_frame(62);  queue_frame(64);
      queue_frame(66);  queue_frame(0);   queue_frame(255); queue_frame(235);
      queue_frame(255); queue_frame(100); queue_frame(110); queue_frame(50);
      queue_frame(30);  queue_frame(60);  queue_frame(60);  queue_frame(60);
      wait_for_drain();

      // The loop is stable well above the new maximum: a frame near target must leave the
      // level untouched, while a large error steps and clamps it.
      write_register(CSR_MAX_LEVEL, 8'd10);
      queue_frame(60);
      queue_frame(200);
      queue_frame(0);
      wait_for_drain();

      // A maximum of zero pins the level at the lower bound whichever way it steps.
      write_register(CSR_TARGET_LUMA, 8'd255);
      write_register(CSR_MAX_LEVEL, 8'd0);
      queue_frame(255);
      queue_frame(0);
      queue_frame(255);
      wait_for_drain();

      // A write to an index beyond the register map must change nothing.
      write_register(CSR_INDEX_WIDTH'(2**CSR_INDEX_WIDTH - 1), 8'd77);

      // Random part in phases, each under its own register setting, extremes first.
      for (phase = 0; phase < 10; phase++) begin
         case (phase)
            0:       begin target = 0;   max_level = 255; end
            1:       begin target = 255; max_level = 255; end
            2:       begin target = 128; max_level = 0;   end
            3:       begin target = $urandom_range(0, 255); max_level = $urandom_range(1, 20); end
            default: begin target = $urandom_range(0, 255); max_level = $urandom_range(0, 255); end
         endcase
         if ($urandom_range(0, 1)) begin
            write_register(CSR_TARGET_LUMA, target[CSR_DATA_WIDTH-1:0]);
            write_register(CSR_MAX_LEVEL, max_level[CSR_DATA_WIDTH-1:0]);
         end else begin
            write_register(CSR_MAX_LEVEL, max_level[CSR_DATA_WIDTH-1:0]);
            write_register(CSR_TARGET_LUMA, target[CSR_DATA_WIDTH-1:0]);
         end
         if (phase % 3 == 0)
            write_register(CSR_INDEX_WIDTH'($urandom_range(2**CSR_INDEX_WIDTH - 1,
                                                           int'(CSR_MAX_LEVEL) + 1)),
                           CSR_DATA_WIDTH'($urandom_range(0, 255)));
         // The closing phase runs with both sides streaming at full rate.
         if (phase == 9)
            @(negedge clock) calm <= 1'b1;
         queue_random_phase(95, target);
         wait_for_drain();
      end

      // Allow for any stray response after the last expected one.
      repeat (8) @(posedge clock);
      if (awaited_exposure.size() != 0) begin
         $error("%0d responses never arrived", awaited_exposure.size());
         failures++;
      end

      $display("Checked %0d frames and %0d responses across %0d register writes.",
               frames_accepted, responses_seen, writes_seen);
      $display("%0d frames held the level while stable; %0d mismatches.",
               holds_seen, failures);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
